/* hdl/stereo_rms_peak_meter_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the meter checker
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef STEREO_RMS_PEAK_METER_DEFINES_SVH
`define STEREO_RMS_PEAK_METER_DEFINES_SVH

// implication checked every clock outside reset
`define SRPM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked every clock outside reset
`define SRPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/srpm_pkg.sv */
// ----------------------------------------------------------------------------
// Meter package
// Types, command codes and constants shared by the meter modules.
// ----------------------------------------------------------------------------
`default_nettype none
package srpm_pkg;
  localparam int MaxBlock  = 4096;
  localparam int BlkW      = $clog2(MaxBlock + 1);
  localparam int CntW      = BlkW;
  localparam int SumW      = 32 + BlkW;
  localparam int LvlW      = 17;
  localparam int QDepth    = 2;
  localparam logic [15:0] LevelDecay = 16'd52429;
  localparam logic [15:0] PeakDecay  = 16'd62259;
  localparam logic [LvlW-1:0] FullScale = 17'd65536;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic signed [15:0] sample;
    logic        last_of_block;
  } in_item_t;

  typedef struct packed {
    logic [LvlW-1:0] level_left;
    logic [LvlW-1:0] level_right;
    logic [LvlW-1:0] peak_left;
    logic [LvlW-1:0] peak_right;
  } out_item_t;

  // work handed from front to back
  typedef struct packed {
    cmd_e            op;
    logic [SumW-1:0] sum_l;
    logic [SumW-1:0] sum_r;
    logic [CntW-1:0] cnt_l;
    logic [CntW-1:0] cnt_r;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_DIV, BK_SQRT, BK_MUL, BK_OUT
  } back_state_e;
endpackage
`default_nettype wire

/* hdl/srpm_front.sv */
// ----------------------------------------------------------------------------
// Meter front end
// Accumulates squares and counts per channel; forms jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module srpm_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 stereo_mode,
  input  wire                 in_valid,
  output logic                in_ready,
  input  srpm_pkg::in_item_t  in_data,
  output logic                job_valid,
  input  wire                 job_ready,
  output srpm_pkg::job_t      job
);
  import srpm_pkg::*;

  logic [SumW-1:0] sum_l, sum_r;
  logic [CntW-1:0] cnt_l, cnt_r;
  logic [BlkW-1:0] taken;
  logic            parity;
  logic [15:0]     mag;
  logic [31:0]     sq;
  logic            acc, take, want_job;
  logic [SumW-1:0] sum_l_next, sum_r_next;
  logic [CntW-1:0] cnt_l_next, cnt_r_next;
  logic            to_l, to_r;

  assign mag = in_data.sample[15] ? 16'(-in_data.sample) : in_data.sample;
  assign sq  = mag * mag;

  assign want_job = (in_data.cmd == CMD_TICK) || (in_data.cmd == CMD_CLEAR) ||
                    ((in_data.cmd == CMD_SAMPLE) && in_data.last_of_block);
  assign in_ready = !want_job || job_ready;
  assign take     = in_valid && in_ready;
  assign acc      = take && (in_data.cmd == CMD_SAMPLE) &&
                    (taken < BlkW'(MaxBlock));
  assign to_l     = !stereo_mode || !parity;
  assign to_r     = !stereo_mode || parity;

  always_comb begin
    sum_l_next = sum_l;
    sum_r_next = sum_r;
    cnt_l_next = cnt_l;
    cnt_r_next = cnt_r;
    if (acc && to_l) begin
      sum_l_next = sum_l + SumW'(sq);
      cnt_l_next = cnt_l + 1'b1;
    end
    if (acc && to_r) begin
      sum_r_next = sum_r + SumW'(sq);
      cnt_r_next = cnt_r + 1'b1;
    end
  end

  assign job_valid = in_valid && want_job;
  always_comb begin
    job.op    = cmd_e'(in_data.cmd);
    job.sum_l = sum_l_next;
    job.sum_r = sum_r_next;
    job.cnt_l = cnt_l_next;
    job.cnt_r = cnt_r_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_l <= '0; sum_r <= '0; cnt_l <= '0; cnt_r <= '0;
      taken <= '0; parity <= 1'b0;
    end else if (take && in_data.cmd == CMD_SAMPLE) begin
      if (in_data.last_of_block) begin
        sum_l <= '0; sum_r <= '0; cnt_l <= '0; cnt_r <= '0;
        taken <= '0; parity <= 1'b0;
      end else begin
        sum_l <= sum_l_next; sum_r <= sum_r_next;
        cnt_l <= cnt_l_next; cnt_r <= cnt_r_next;
        if (acc) begin
          taken <= taken + 1'b1;
          if (stereo_mode) parity <= !parity;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/srpm_queue.sv */
// ----------------------------------------------------------------------------
// Meter job queue
// Short FIFO between front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
module srpm_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              wr_valid,
  output logic             wr_ready,
  input  srpm_pkg::job_t   wr_data,
  output logic             rd_valid,
  input  wire              rd_ready,
  output srpm_pkg::job_t   rd_data
);
  import srpm_pkg::*;
  localparam int PtrW = $clog2(QDepth);

  job_t            mem [QDepth];
  logic [PtrW-1:0] wp, rp;
  logic [PtrW:0]   fill;
  logic            wr, rd;

  assign wr_ready = fill != (PtrW+1)'(QDepth);
  assign rd_valid = fill != '0;
  assign rd_data  = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; fill <= '0;
    end else begin
      if (wr) wp <= (wp == PtrW'(QDepth-1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == PtrW'(QDepth-1)) ? '0 : rp + 1'b1;
      fill <= fill + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end
endmodule
`default_nettype wire

/* hdl/srpm_back.sv */
// ----------------------------------------------------------------------------
// Meter back end
// Divides, takes square roots, updates held levels and peaks, drives output.
// ----------------------------------------------------------------------------
`default_nettype none
module srpm_back (
  input  wire                clk,
  input  wire                rst,
  input  wire                job_valid,
  output logic               job_ready,
  input  srpm_pkg::job_t     job,
  output logic               out_valid,
  input  wire                out_ready,
  output srpm_pkg::out_item_t out_data
);
  import srpm_pkg::*;
  localparam int StepW = $clog2(SumW + 1);

  back_state_e state, state_next;
  logic [LvlW-1:0] lvl_l, lvl_r, pk_l, pk_r;
  // restoring divider, both channels side by side
  logic [SumW-1:0] q_l, q_r;
  logic [CntW:0]   rm_l, rm_r;
  logic [CntW-1:0] d_l, d_r;
  logic [StepW-1:0] step;
  // bit-pair square root
  logic [SumW-1:0] v_l, v_r, rs_l, rs_r, bit_v;
  logic [SumW-1:0] rb_l, rb_r;
  logic            ge_l, ge_r;
  logic [CntW:0]   tr_l, tr_r;
  logic [SumW+2:0] l6_l, l6_r;
  logic [LvlW-1:0] nl_l, nl_r;
  logic [LvlW+15:0] dl_l, dl_r, dp_l, dp_r;

  assign tr_l = {rm_l[CntW-1:0], q_l[SumW-1]};
  assign tr_r = {rm_r[CntW-1:0], q_r[SumW-1]};
  assign rb_l = rs_l + bit_v;
  assign rb_r = rs_r + bit_v;
  assign ge_l = v_l >= rb_l;
  assign ge_r = v_r >= rb_r;
  assign l6_l = (SumW+3)'(rs_l) * 3'd6;
  assign l6_r = (SumW+3)'(rs_r) * 3'd6;
  assign nl_l = (d_l == '0) ? '0 :
                (l6_l > (SumW+3)'(FullScale)) ? FullScale : LvlW'(l6_l);
  assign nl_r = (d_r == '0) ? '0 :
                (l6_r > (SumW+3)'(FullScale)) ? FullScale : LvlW'(l6_r);
  assign dl_l = lvl_l * LevelDecay;
  assign dl_r = lvl_r * LevelDecay;
  assign dp_l = pk_l * PeakDecay;
  assign dp_r = pk_r * PeakDecay;

  assign job_ready = state == BK_IDLE;
  assign out_valid = state == BK_OUT;
  assign out_data  = '{level_left: lvl_l, level_right: lvl_r,
                       peak_left: pk_l, peak_right: pk_r};

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (job_valid) begin
          if (job.op == CMD_SAMPLE) state_next = BK_DIV;
          else                      state_next = BK_OUT;
        end
      end
      BK_DIV:  if (step == StepW'(SumW - 1)) state_next = BK_SQRT;
      // leave after the step on the lowest bit pair
      BK_SQRT: if (bit_v == SumW'(1)) state_next = BK_MUL;
      BK_MUL:  state_next = BK_OUT;
      BK_OUT:  if (out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_l <= '0; lvl_r <= '0; pk_l <= '0; pk_r <= '0;
    end else begin
      case (state)
        BK_IDLE: begin
          if (job_valid) begin
            if (job.op == CMD_TICK) begin
              lvl_l <= LvlW'(dl_l >> 16); lvl_r <= LvlW'(dl_r >> 16);
              pk_l  <= LvlW'(dp_l >> 16); pk_r  <= LvlW'(dp_r >> 16);
            end else if (job.op == CMD_CLEAR) begin
              lvl_l <= '0; lvl_r <= '0; pk_l <= '0; pk_r <= '0;
            end
          end
        end
        BK_MUL: begin
          lvl_l <= nl_l; lvl_r <= nl_r;
          pk_l  <= (nl_l > pk_l) ? nl_l : LvlW'(dp_l >> 16);
          pk_r  <= (nl_r > pk_r) ? nl_r : LvlW'(dp_r >> 16);
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        q_l <= job.sum_l; q_r <= job.sum_r;
        d_l <= job.cnt_l; d_r <= job.cnt_r;
        rm_l <= '0; rm_r <= '0; step <= '0;
      end
      BK_DIV: begin
        // shift one quotient bit in per cycle
        if (tr_l >= {1'b0, d_l}) begin
          rm_l <= tr_l - {1'b0, d_l}; q_l <= {q_l[SumW-2:0], 1'b1};
        end else begin
          rm_l <= tr_l; q_l <= {q_l[SumW-2:0], 1'b0};
        end
        if (tr_r >= {1'b0, d_r}) begin
          rm_r <= tr_r - {1'b0, d_r}; q_r <= {q_r[SumW-2:0], 1'b1};
        end else begin
          rm_r <= tr_r; q_r <= {q_r[SumW-2:0], 1'b0};
        end
        step <= step + 1'b1;
        if (step == StepW'(SumW - 1)) begin
          v_l <= (d_l == '0) ? '0 : ((tr_l >= {1'b0, d_l}) ?
                 {q_l[SumW-2:0], 1'b1} : {q_l[SumW-2:0], 1'b0});
          v_r <= (d_r == '0) ? '0 : ((tr_r >= {1'b0, d_r}) ?
                 {q_r[SumW-2:0], 1'b1} : {q_r[SumW-2:0], 1'b0});
          rs_l <= '0; rs_r <= '0;
          bit_v <= SumW'(1) << (2 * ((SumW - 1) / 2));
        end
      end
      BK_SQRT: begin
        if (ge_l) begin
          v_l <= v_l - rb_l; rs_l <= (rs_l >> 1) + bit_v;
        end else rs_l <= rs_l >> 1;
        if (ge_r) begin
          v_r <= v_r - rb_r; rs_r <= (rs_r >> 1) + bit_v;
        end else rs_r <= rs_r >> 1;
        bit_v <= bit_v >> 2;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* hdl/stereo_rms_peak_meter.sv */
// ----------------------------------------------------------------------------
// Stereo RMS level meter with peak hold
// Top level: configuration port, front end, job queue and back end.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : commands (sample, tick, clear) with valid/ready.
//   out_* : one result per tick, clear, or sample marked last_of_block.
//   APB   : register 0 at address 0, bit 0 = stereo_mode (reset 1).
// Samples that do not end a block are taken one per cycle and give no
// result. Tick and clear go through the queue and then straight to the
// back end's output state. A block end runs a one-bit-per-cycle divider
// and then a two-bit-per-cycle square root before its result; the back
// end handles one job at a time, and a 2-entry queue lets the front keep
// taking samples meanwhile. Cmd 3 is dropped with no result.
// Reset clears accumulators, held values and the queue. When out_ready
// is low the result holds; the back end and then the queue fill and the
// input stalls only on a job that cannot be queued.
// ----------------------------------------------------------------------------
`default_nettype none
module stereo_rms_peak_meter (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  srpm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output srpm_pkg::out_item_t  out_data,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire [1:0]            paddr,
  input  wire [31:0]           pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import srpm_pkg::*;

  logic stereo_mode;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {31'd0, stereo_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) stereo_mode <= 1'b1;
    else if (psel && penable && pwrite && paddr == 2'd0) stereo_mode <= pwdata[0];
  end

  srpm_front u_front (
    .clk, .rst, .stereo_mode, .in_valid, .in_ready, .in_data,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  srpm_queue u_queue (
    .clk, .rst, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  srpm_back u_back (
    .clk, .rst, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire

/* hdl/srpm_checker.sv */
// ----------------------------------------------------------------------------
// Meter port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_rms_peak_meter_defines.svh"
module srpm_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 out_valid,
  input wire                 out_ready,
  input srpm_pkg::out_item_t out_data,
  input wire                 pready
);
  import srpm_pkg::*;
  `SRPM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped while stalled")
  `SRPM_ASSERT_IMP(a_lvl_l, clk, rst, out_valid, out_data.level_left <= FullScale, "left level over full scale")
  `SRPM_ASSERT_IMP(a_lvl_r, clk, rst, out_valid, out_data.level_right <= FullScale, "right level over full scale")
  `SRPM_ASSERT_IMP(a_pready, clk, rst, 1'b1, pready, "pready low")
endmodule

bind stereo_rms_peak_meter srpm_checker u_checker (
  .clk, .rst, .out_valid, .out_ready, .out_data, .pready
);
`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Stereo RMS peak meter testbench
// Drives sample, tick and clear transactions with random gaps on both sides,
// predicts levels and peaks per channel, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import srpm_pkg::*;

  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  stereo_rms_peak_meter u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // meter model state
  logic        mode_stereo;
  logic [63:0] acc_l, acc_r;
  int unsigned n_l, n_r, taken;
  logic        odd_chan;
  logic [16:0] lvl_l, lvl_r, pk_l, pk_r;

  out_item_t level_queue[$];
  int errors = 0;
  int n_results = 0;
  int n_sent = 0;
  int idle_cycles = 0;
  bit stall_en = 1'b1;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [16:0] rms_of(logic [63:0] s, int unsigned c);
    logic [63:0] lv;
    if (c == 0) return '0;
    lv = 6 * isqrt64(s / c);
    return (lv > 64'd65536) ? FullScale : lv[16:0];
  endfunction

  function automatic logic [16:0] decay(logic [16:0] v, logic [15:0] f);
    logic [63:0] p;
    p = 64'(v) * 64'(f);
    return p[32:16];
  endfunction

  task automatic predict_meter(in_item_t it);
    logic [63:0] sq;
    int signed s;
    case (cmd_e'(it.cmd))
      CMD_TICK: begin
        lvl_l = decay(lvl_l, LevelDecay);
        lvl_r = decay(lvl_r, LevelDecay);
        pk_l = decay(pk_l, PeakDecay);
        pk_r = decay(pk_r, PeakDecay);
        level_queue.push_back('{lvl_l, lvl_r, pk_l, pk_r});
      end
      CMD_CLEAR: begin
        lvl_l = 0; lvl_r = 0; pk_l = 0; pk_r = 0;
        level_queue.push_back('{lvl_l, lvl_r, pk_l, pk_r});
      end
      CMD_SAMPLE: begin
        if (taken < MaxBlock) begin
          s = it.sample;
          if (s < 0) s = -s;
          sq = 64'(s) * 64'(s);
          taken++;
          if (!mode_stereo) begin
            acc_l += sq; acc_r += sq; n_l++; n_r++;
          end else begin
            if (!odd_chan) begin
              acc_l += sq; n_l++;
            end else begin
              acc_r += sq; n_r++;
            end
            odd_chan = ~odd_chan;
          end
        end
        if (it.last_of_block) begin
          lvl_l = rms_of(acc_l, n_l);
          lvl_r = rms_of(acc_r, n_r);
          pk_l = (lvl_l > pk_l) ? lvl_l : decay(pk_l, PeakDecay);
          pk_r = (lvl_r > pk_r) ? lvl_r : decay(pk_r, PeakDecay);
          acc_l = 0; acc_r = 0; n_l = 0; n_r = 0; odd_chan = 0; taken = 0;
          level_queue.push_back('{lvl_l, lvl_r, pk_l, pk_r});
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [16:0] got, logic [16:0] want);
    $display("MISMATCH result %0d %s: got %0d want %0d", n_results, what, got, want);
    errors++;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (level_queue.size() == 0) begin
        $display("MISMATCH unexpected result %0d", n_results);
        errors++;
      end else begin
        want = level_queue.pop_front();
        if (out_data.level_left != want.level_left)
          report_mismatch("level_left", out_data.level_left, want.level_left);
        if (out_data.level_right != want.level_right)
          report_mismatch("level_right", out_data.level_right, want.level_right);
        if (out_data.peak_left != want.peak_left)
          report_mismatch("peak_left", out_data.peak_left, want.peak_left);
        if (out_data.peak_right != want.peak_right)
          report_mismatch("peak_right", out_data.peak_right, want.peak_right);
      end
      n_results++;
    end
  end

  int rx_hold = 0;
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (stall_en && $urandom_range(0, 3) == 0) begin
      rx_hold <= gap_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on transactions
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // valid stays up between back-to-back items; drop it only for a gap
  task automatic send_item(logic [1:0] cmd, logic [15:0] smp, logic last);
    in_item_t it;
    int g;
    g = stall_en ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    it.cmd = cmd; it.sample = smp; it.last_of_block = last;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_meter(it);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (level_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= {31'd0, m};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mode_stereo = m;
    @(posedge clk);
  endtask

  task automatic send_block(int len, int kind);
    logic [15:0] v;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: v = 16'h8000;
        1: v = 16'h7FFF;
        2: v = 16'($urandom_range(0, 255) - 128);
        default: v = 16'($urandom);
      endcase
      send_item(CMD_SAMPLE, v, i == len - 1);
    end
  endtask

  task automatic test_directed();
    send_item(CMD_TICK, 16'h0000, 1'b0);
    send_item(CMD_SAMPLE, 16'h0000, 1'b1);
    send_block(2, 0);
    send_block(3, 1);
    send_item(CMD_TICK, 16'hFFFF, 1'b1);
    send_item(CMD_NONE, 16'h1234, 1'b1);
    send_block(4, 3);
    send_item(CMD_CLEAR, 16'h5555, 1'b0);
    send_item(CMD_SAMPLE, 16'hFFFF, 1'b0);
    send_item(CMD_SAMPLE, 16'h0001, 1'b1);
    send_item(CMD_TICK, 16'h0000, 1'b0);
    drain();
  endtask

  task automatic test_mono();
    write_mode(1'b0);
    send_block(3, 1);
    send_item(CMD_TICK, 16'h0, 1'b0);
    for (int b = 0; b < 60; b++)
      send_block($urandom_range(1, 8), $urandom_range(0, 3));
    drain();
  endtask

  task automatic test_random(int n, logic m);
    int r, cnt;
    write_mode(m);
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 19);
      if (r < 15) begin
        r = $urandom_range(1, 12);
        send_block(r, $urandom_range(0, 9) < 2 ? $urandom_range(0, 1) : 3);
        cnt += r;
      end else if (r < 17) begin
        send_item(CMD_TICK, 16'($urandom), 1'($urandom));
        cnt++;
      end else if (r < 18) begin
        send_item(CMD_CLEAR, 16'($urandom), 1'($urandom));
        cnt++;
      end else if (r < 19) begin
        send_item(CMD_NONE, 16'($urandom), 1'($urandom));
      end else begin
        send_item(CMD_SAMPLE, 16'($urandom), 1'b0);
        cnt++;
      end
    end
    send_item(CMD_SAMPLE, 16'($urandom), 1'b1);
    drain();
  endtask

  initial begin
    mode_stereo = 1; acc_l = 0; acc_r = 0; n_l = 0; n_r = 0; taken = 0;
    odd_chan = 0; lvl_l = 0; lvl_r = 0; pk_l = 0; pk_r = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_mono();
    test_random(450, 1'b1);
    test_random(400, 1'b0);
    test_random(450, 1'b1);
    $display("sent %0d items, checked %0d results", n_sent, n_results);
    $display("covered stereo and mono modes, ticks, clears, idle codes, full-scale blocks");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
